[hdl/swap_page_mapper_fifo_defines.svh]
// Assertion macros shared by the page mapper modules
`ifndef SWAP_PAGE_MAPPER_FIFO_DEFINES_SVH
`define SWAP_PAGE_MAPPER_FIFO_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define SPM_CHECK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define SPM_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/spm_pkg.sv]
// Shared types and constants of the swap page mapper
package spm_pkg;

  localparam int MAX_SLOTS_DEFAULT = 128;

  localparam int VADDR_W = 24;
  localparam int PADDR_W = 19;
  localparam int SLOT_W  = 7;
  localparam int PAGE_W  = 15;
  localparam int TAG_W   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int PSEL_W     = 2;
  localparam int NSLOT_W    = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS     = 2'd1;

  // page size codes
  localparam logic [PSEL_W-1:0] PSEL_1K = 2'd0;
  localparam logic [PSEL_W-1:0] PSEL_2K = 2'd1;
  localparam logic [PSEL_W-1:0] PSEL_4K = 2'd2;

  localparam logic [PSEL_W-1:0]  PSEL_RESET  = PSEL_2K;
  localparam logic [NSLOT_W-1:0] SLOTS_RESET = 8'd64;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic scan;
    logic victim_rd;
    logic victim_cap;
    logic load_out;
  } spm_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last_hit;
    logic match;
    logic exhausted;
  } spm_status_t;

endpackage

[hdl/spm_if.sv]
// Request, response and configuration channel interfaces
interface spm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [spm_pkg::VADDR_W-1:0] virt_addr;
  modport source (output valid, op, virt_addr, input ready);
  modport sink (input valid, op, virt_addr, output ready);
endinterface

interface spm_resp_if;
  logic                        valid;
  logic                        ready;
  logic [spm_pkg::PADDR_W-1:0] phys_addr;
  logic [spm_pkg::SLOT_W-1:0]  slot;
  logic                        hit;
  logic                        writeback;
  logic [spm_pkg::PAGE_W-1:0]  evicted_page;
  logic                        fill;
  logic [spm_pkg::PAGE_W-1:0]  fill_page;
  modport source (output valid, phys_addr, slot, hit, writeback, evicted_page, fill,
                  fill_page, input ready);
  modport sink (input valid, phys_addr, slot, hit, writeback, evicted_page, fill,
                fill_page, output ready);
endinterface

interface spm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [spm_pkg::CFG_IDX_W-1:0]  index;
  logic [spm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/swap_page_mapper_fifo.sv]
// Swap page mapper top level: round-robin replacement over page RAM slots.
// One request is in flight at a time. A repeat of the last page skips the tag search; the
// search reads one tag per cycle and stops at a hit, and a miss reads the victim's tag
// after it. After reset a clearing pass zeroes the tag table; requests wait.
module swap_page_mapper_fifo #(
  parameter int MAX_SLOTS = spm_pkg::MAX_SLOTS_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  spm_req_if.sink     req,
  spm_resp_if.source  resp,
  spm_cfg_if.sink     cfg
);

  spm_pkg::spm_cmd_t    cmd;
  spm_pkg::spm_status_t status;

  assign cfg.ready = 1'b1;

  spm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (resp.valid),
    .out_ready (resp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  spm_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .in_op        (req.op),
    .in_virt_addr (req.virt_addr),
    .phys_addr    (resp.phys_addr),
    .slot         (resp.slot),
    .hit          (resp.hit),
    .writeback    (resp.writeback),
    .evicted_page (resp.evicted_page),
    .fill         (resp.fill),
    .fill_page    (resp.fill_page)
  );

endmodule

[hdl/spm_ctrl.sv]
// Controller state machine of the swap page mapper
`include "swap_page_mapper_fifo_defines.svh"

module spm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spm_pkg::spm_cmd_t    cmd,
  input  spm_pkg::spm_status_t status
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_VIC_RD  = 3'd3;
  localparam logic [2:0] ST_VIC_CAP = 3'd4;
  localparam logic [2:0] ST_RESULT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.last_hit ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match) state_next = ST_RESULT;
        else if (status.exhausted) state_next = ST_VIC_RD;
      end
      ST_VIC_RD: begin
        cmd.victim_rd = 1'b1;
        state_next    = ST_VIC_CAP;
      end
      ST_VIC_CAP: begin
        cmd.victim_cap = 1'b1;
        state_next     = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `SPM_CHECK_NEXT(a_result_loads, clk, rst, (state == ST_RESULT) && out_free, (state == ST_IDLE) && out_valid, "result not presented")
  `SPM_CHECK_NEXT(a_scan_hit_done, clk, rst, (state == ST_SCAN) && status.match, state == ST_RESULT, "scan hit not finished")
  `SPM_CHECK_NEXT(a_shortcut, clk, rst, cmd.accept && status.last_hit, state == ST_RESULT, "last page shortcut missed")

endmodule

[hdl/spm_dp.sv]
// Datapath of the swap page mapper: tag memory, victim pointer, address maths
`include "swap_page_mapper_fifo_defines.svh"

module spm_dp #(
  parameter int MAX_SLOTS = spm_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spm_pkg::spm_cmd_t              cmd,
  output spm_pkg::spm_status_t           status,
  input  logic                           cfg_wr,
  input  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_op,
  input  logic [spm_pkg::VADDR_W-1:0]    in_virt_addr,
  output logic [spm_pkg::PADDR_W-1:0]    phys_addr,
  output logic [spm_pkg::SLOT_W-1:0]     slot,
  output logic                           hit,
  output logic                           writeback,
  output logic [spm_pkg::PAGE_W-1:0]     evicted_page,
  output logic                           fill,
  output logic [spm_pkg::PAGE_W-1:0]     fill_page
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  logic [spm_pkg::TAG_W-1:0] tag_mem [MAX_SLOTS];
  logic [spm_pkg::TAG_W-1:0] rdata;
  logic [SW-1:0]             rd_addr;

  logic [spm_pkg::PSEL_W-1:0]  page_size_sel;
  logic [spm_pkg::NSLOT_W-1:0] slots_in_use;

  logic [spm_pkg::PAGE_W-1:0] last_page;
  logic [SW-1:0]              last_slot;
  logic [SW-1:0]              next_victim;
  logic [SW-1:0]              clr_idx;

  logic [CW-1:0] scan_idx;
  logic [SW-1:0] rd_idx;
  logic          rd_valid;

  logic                        op_r;
  logic [spm_pkg::VADDR_W-1:0] addr_r;
  logic [spm_pkg::PAGE_W-1:0]  page_r;
  logic [SW-1:0]               slot_r;
  logic [SW-1:0]               victim_r;
  logic                        hit_r;
  logic                        wb_r;
  logic [spm_pkg::PAGE_W-1:0]  evicted_r;
  logic                        fill_r;

  logic [CW-1:0]              n;
  logic [spm_pkg::PAGE_W-1:0] in_page;
  logic [SW-1:0]              victim;
  logic [CW-1:0]              victim_inc;
  logic [SW-1:0]              victim_next;
  logic [spm_pkg::PADDR_W-1:0] slot_base;
  logic [spm_pkg::PADDR_W-1:0] offset;

  // clamp the slot count to 2 .. MAX_SLOTS
  always_comb begin
    if (slots_in_use < 8'd2) n = CW'(2);
    else if (32'(slots_in_use) > 32'(MAX_SLOTS)) n = CW'(MAX_SLOTS);
    else n = CW'(slots_in_use);
  end

  always_comb begin
    case (page_size_sel)
      spm_pkg::PSEL_1K: in_page = spm_pkg::PAGE_W'(in_virt_addr[23:10]) + 15'd1;
      spm_pkg::PSEL_4K: in_page = spm_pkg::PAGE_W'(in_virt_addr[23:12]) + 15'd1;
      default:          in_page = spm_pkg::PAGE_W'(in_virt_addr[23:11]) + 15'd1;
    endcase
  end

  always_comb begin
    case (page_size_sel)
      spm_pkg::PSEL_1K: begin
        slot_base = spm_pkg::PADDR_W'(slot_r) << 10;
        offset    = spm_pkg::PADDR_W'(addr_r[9:0]);
      end
      spm_pkg::PSEL_4K: begin
        slot_base = spm_pkg::PADDR_W'(slot_r) << 12;
        offset    = spm_pkg::PADDR_W'(addr_r[11:0]);
      end
      default: begin
        slot_base = spm_pkg::PADDR_W'(slot_r) << 11;
        offset    = spm_pkg::PADDR_W'(addr_r[10:0]);
      end
    endcase
  end

  // a stale pointer falls back to slot 1; advance and wrap below the count
  always_comb begin
    if (next_victim == '0 || CW'(next_victim) >= n) victim = SW'(1);
    else victim = next_victim;
    victim_inc = CW'(victim) + CW'(1);
    if (victim_inc >= n) victim_next = SW'(1);
    else victim_next = victim_inc[SW-1:0];
  end

  assign status.clear_done = (clr_idx == SW'(MAX_SLOTS - 1));
  assign status.last_hit   = (in_page == last_page);
  assign status.match      = rd_valid && (rdata[spm_pkg::PAGE_W-1:0] == page_r);
  assign status.exhausted  = !rd_valid && (scan_idx >= n);

  assign rd_addr = cmd.victim_rd ? victim : scan_idx[SW-1:0];

  always_ff @(posedge clk) begin
    rdata <= tag_mem[rd_addr];
    if (cmd.clear_en) begin
      tag_mem[clr_idx] <= '0;
    end else if (cmd.load_out && (fill_r || op_r)) begin
      tag_mem[slot_r] <= {op_r, page_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size_sel <= spm_pkg::PSEL_RESET;
      slots_in_use  <= spm_pkg::SLOTS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        spm_pkg::CFG_PAGE_SIZE: page_size_sel <= cfg_data[spm_pkg::PSEL_W-1:0];
        spm_pkg::CFG_SLOTS:     slots_in_use  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_page   <= '0;
      last_slot   <= '0;
      next_victim <= SW'(1);
      clr_idx     <= '0;
      rd_valid    <= 1'b0;
      scan_idx    <= '0;
    end else begin
      if (cmd.clear_en) clr_idx <= clr_idx + SW'(1);
      if (cmd.accept) begin
        rd_valid <= 1'b0;
        scan_idx <= CW'(1);
        if (!status.last_hit) last_page <= in_page;
      end
      if (cmd.scan) begin
        rd_valid <= (scan_idx < n);
        rd_idx   <= scan_idx[SW-1:0];
        if (scan_idx < n) scan_idx <= scan_idx + CW'(1);
      end
      if (cmd.victim_rd) next_victim <= victim_next;
      if (cmd.load_out) last_slot <= slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_op;
      addr_r    <= in_virt_addr;
      page_r    <= in_page;
      slot_r    <= last_slot;
      hit_r     <= status.last_hit;
      wb_r      <= 1'b0;
      evicted_r <= '0;
      fill_r    <= 1'b0;
    end
    if (cmd.scan && status.match) begin
      slot_r <= rd_idx;
      hit_r  <= 1'b1;
    end
    if (cmd.victim_rd) victim_r <= victim;
    if (cmd.victim_cap) begin
      slot_r    <= victim_r;
      hit_r     <= 1'b0;
      fill_r    <= 1'b1;
      wb_r      <= rdata[spm_pkg::TAG_W-1];
      evicted_r <= rdata[spm_pkg::TAG_W-1] ? rdata[spm_pkg::PAGE_W-1:0] : '0;
    end
    if (cmd.load_out) begin
      phys_addr    <= slot_base + offset;
      slot         <= spm_pkg::SLOT_W'(slot_r);
      hit          <= hit_r;
      writeback    <= wb_r;
      evicted_page <= evicted_r;
      fill         <= fill_r;
      fill_page    <= fill_r ? page_r : '0;
    end
  end

  `SPM_CHECK_NOW(a_victim_range, clk, rst, cmd.victim_rd, (victim != '0) && (CW'(victim) < n), "victim out of range")
  `SPM_CHECK_NOW(a_fill_is_miss, clk, rst, cmd.load_out && fill_r, !hit_r, "fill flagged on a hit")

endmodule

[bench/swap_page_mapper_fifo_test.sv]
// Self-checking bench for the swap page mapper: directed table, then paced random accesses
module swap_page_mapper_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS   = 128;
  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 100;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // code 3 is not a real page size; the block treats it as 2 KiB
  localparam logic [spm_pkg::PSEL_W-1:0] PSEL_UNUSED = 2'd3;

  typedef struct packed {
    logic [spm_pkg::PADDR_W-1:0] phys_addr;
    logic [spm_pkg::SLOT_W-1:0]  slot;
    logic                        hit;
    logic                        writeback;
    logic [spm_pkg::PAGE_W-1:0]  evicted_page;
    logic                        fill;
    logic [spm_pkg::PAGE_W-1:0]  fill_page;
  } map_result_t;

  typedef enum logic [0:0] {ROW_ACCESS, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic                             op;
    logic [spm_pkg::VADDR_W-1:0]      addr;
    logic [spm_pkg::CFG_IDX_W-1:0]    reg_idx;
    logic [spm_pkg::CFG_DATA_W-1:0]   reg_val;
    logic                             typed;
    map_result_t                      want;
  } stim_row_t;

  localparam map_result_t NO_RESULT = '0;

  localparam stim_row_t DIRECTED [25] = '{
    // first touch after reset: slot 1, fill of page 1
    '{ROW_ACCESS, OP_READ, 24'h000000, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b1,
      '{19'h00800, 7'd1, 1'b0, 1'b0, 15'd0, 1'b1, 15'd1}},
    // same page again: last-page shortcut
    '{ROW_ACCESS, OP_READ, 24'h0007FF, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b1,
      '{19'h00FFF, 7'd1, 1'b1, 1'b0, 15'd0, 1'b0, 15'd0}},
    // top address: page 8192 into slot 2
    '{ROW_ACCESS, OP_WRITE, 24'hFFFFFF, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b1,
      '{19'h017FF, 7'd2, 1'b0, 1'b0, 15'd0, 1'b1, 15'h2000}},
    '{ROW_ACCESS, OP_WRITE, 24'h000400, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_READ,  24'hFFF800, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, OP_READ,  24'h000000, spm_pkg::CFG_SLOTS,     8'd2, 1'b0, NO_RESULT},
    // victim pointer now beyond the slot count: slot 1 goes, and it is dirty
    '{ROW_ACCESS, OP_WRITE, 24'h123456, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b1,
      '{19'h00C56, 7'd1, 1'b0, 1'b1, 15'd1, 1'b1, 15'h0247}},
    '{ROW_ACCESS, OP_READ,  24'h000000, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, OP_READ,  24'h000000, spm_pkg::CFG_SLOTS,     8'd0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_READ,  24'h000800, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, OP_READ,  24'h000000, spm_pkg::CFG_SLOTS,     8'd255, 1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_WRITE, 24'h7FF801, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_READ,  24'h7FF802, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, OP_READ,  24'h000000, spm_pkg::CFG_PAGE_SIZE, {6'd0, PSEL_UNUSED}, 1'b0,
      NO_RESULT},
    '{ROW_ACCESS, OP_READ,  24'h7FF800, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, OP_READ,  24'h000000, spm_pkg::CFG_PAGE_SIZE, {6'd0, spm_pkg::PSEL_1K},
      1'b0, NO_RESULT},
    // same page number under the new size: shortcut still taken
    '{ROW_ACCESS, OP_READ,  24'h3FFC00, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_WRITE, 24'hFFFFFF, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, OP_READ,  24'h000000, spm_pkg::CFG_PAGE_SIZE, {6'd0, spm_pkg::PSEL_4K},
      1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_READ,  24'hFFFFFF, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_WRITE, 24'h000FFF, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, OP_READ,  24'h000000, spm_pkg::CFG_SLOTS,     8'd128, 1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_READ,  24'h5A5A5A, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ACCESS, OP_WRITE, 24'hA5A5A5, spm_pkg::CFG_PAGE_SIZE, 8'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, OP_READ,  24'h000000, spm_pkg::CFG_PAGE_SIZE, {6'd0, spm_pkg::PSEL_2K},
      1'b0, NO_RESULT}
  };

  localparam logic [spm_pkg::PSEL_W-1:0] PHASE_PSEL [RAND_PHASES] = '{
    spm_pkg::PSEL_2K, spm_pkg::PSEL_1K, spm_pkg::PSEL_4K, PSEL_UNUSED,
    spm_pkg::PSEL_1K, spm_pkg::PSEL_4K, spm_pkg::PSEL_2K, spm_pkg::PSEL_2K
  };
  localparam logic [spm_pkg::NSLOT_W-1:0] PHASE_SLOTS [RAND_PHASES] = '{
    8'd8, 8'd128, 8'd3, 8'd40, 8'd2, 8'd128, 8'd255, 8'd17
  };
  // sender idle and receiver stall percentages, one pair per two settings
  localparam int PHASE_IDLE  [4] = '{0, 64, 0, 35};
  localparam int PHASE_STALL [4] = '{0, 0, 64, 35};

  logic clk;
  logic rst;

  spm_req_if  req_bus ();
  spm_resp_if resp_bus ();
  spm_cfg_if  cfg_bus ();

  swap_page_mapper_fifo #(.MAX_SLOTS(MAX_SLOTS)) dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_bus),
    .resp (resp_bus),
    .cfg  (cfg_bus)
  );

  // predictor state
  logic [spm_pkg::PSEL_W-1:0]  cur_psel;
  logic [spm_pkg::NSLOT_W-1:0] cur_slots;
  logic [spm_pkg::TAG_W-1:0]   tag_mem [MAX_SLOTS];
  logic [spm_pkg::PAGE_W-1:0]  mru_page;
  logic [spm_pkg::SLOT_W-1:0]  mru_slot;
  int unsigned                 victim_ptr;

  map_result_t pending [$];

  int idle_pct;
  int stall_pct;
  int requests_sent;
  int results_seen;
  int errors;
  int quiet_cycles;
  int hits_seen;
  int fills_seen;
  int writebacks_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned page_shift(input logic [spm_pkg::PSEL_W-1:0] sel);
    case (sel)
      spm_pkg::PSEL_1K: begin
        return 10;
      end
      spm_pkg::PSEL_4K: begin
        return 12;
      end
      default: begin
        return 11;
      end
    endcase
  endfunction

  function automatic int unsigned slot_limit(input logic [spm_pkg::NSLOT_W-1:0] n);
    if (n < 2) return 2;
    if (n > MAX_SLOTS) return MAX_SLOTS;
    return n;
  endfunction

  function automatic map_result_t map_access(input logic wr,
                                             input logic [spm_pkg::VADDR_W-1:0] va);
    int unsigned                shift;
    int unsigned                n;
    int unsigned                vic;
    int unsigned                k;
    logic [spm_pkg::PAGE_W-1:0] pg;
    logic [spm_pkg::TAG_W-1:0]  old;
    logic                       found;
    map_result_t                r;
    shift = page_shift(cur_psel);
    n = slot_limit(cur_slots);
    pg = spm_pkg::PAGE_W'((va >> shift) + 1);
    r = '0;
    found = 1'b0;
    if (pg == mru_page) begin
      r.slot = mru_slot;
      r.hit = 1'b1;
      found = 1'b1;
    end else begin
      mru_page = pg;
      for (k = 1; k < n && !found; k++) begin
        if (tag_mem[k][spm_pkg::PAGE_W-1:0] == pg) begin
          r.slot = spm_pkg::SLOT_W'(k);
          r.hit = 1'b1;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      vic = victim_ptr;
      if (vic == 0 || vic >= n) vic = 1;
      victim_ptr = vic + 1;
      if (victim_ptr >= n) victim_ptr = 1;
      old = tag_mem[vic];
      if (old[spm_pkg::TAG_W-1]) begin
        r.writeback = 1'b1;
        r.evicted_page = old[spm_pkg::PAGE_W-1:0];
      end
      tag_mem[vic] = spm_pkg::TAG_W'(pg);
      r.fill = 1'b1;
      r.fill_page = pg;
      r.slot = spm_pkg::SLOT_W'(vic);
    end
    mru_slot = r.slot;
    if (wr) tag_mem[r.slot][spm_pkg::TAG_W-1] = 1'b1;
    r.phys_addr = spm_pkg::PADDR_W'((32'(r.slot) << shift) +
                                    (va & ((32'd1 << shift) - 1)));
    hits_seen += r.hit;
    fills_seen += r.fill;
    writebacks_seen += r.writeback;
    return r;
  endfunction

  task automatic issue_access(input logic wr, input logic [spm_pkg::VADDR_W-1:0] va,
                              input logic typed, input map_result_t typed_want);
    map_result_t want;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.op <= wr;
    req_bus.virt_addr <= va;
    do @(posedge clk); while (!req_bus.ready);
    // predictor always advances, even where the row gives its own answer
    want = map_access(wr, va);
    if (typed) want = typed_want;
    pending.push_back(want);
    requests_sent++;
  endtask

  task automatic drain_requests();
    @(negedge clk) req_bus.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [spm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [spm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == spm_pkg::CFG_PAGE_SIZE) cur_psel = val[spm_pkg::PSEL_W-1:0];
    else if (idx == spm_pkg::CFG_SLOTS) cur_slots = val;
    @(negedge clk) cfg_bus.valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: response %0d %s expected 0x%0h, got 0x%0h",
               $time, results_seen, name, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk) resp_bus.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : response_check
    map_result_t want;
    if (!rst && resp_bus.valid && resp_bus.ready) begin
      if (pending.size() == 0) begin
        $display("%0t ns: response with no request pending, expected none, got slot %0d phys 0x%0h",
                 $time, resp_bus.slot, resp_bus.phys_addr);
        errors++;
      end else begin
        want = pending.pop_front();
        check_field("phys_addr", 32'(want.phys_addr), 32'(resp_bus.phys_addr));
        check_field("slot", 32'(want.slot), 32'(resp_bus.slot));
        check_field("hit", 32'(want.hit), 32'(resp_bus.hit));
        check_field("writeback", 32'(want.writeback), 32'(resp_bus.writeback));
        check_field("evicted_page", 32'(want.evicted_page), 32'(resp_bus.evicted_page));
        check_field("fill", 32'(want.fill), 32'(resp_bus.fill));
        check_field("fill_page", 32'(want.fill_page), 32'(resp_bus.fill_page));
      end
      results_seen++;
    end
  end

  // stop a hung run: count cycles in which no channel moves anything
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (resp_bus.valid && resp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [spm_pkg::VADDR_W-1:0] va;
    logic [spm_pkg::VADDR_W-1:0] prev_va;
    logic                        wr;
    int unsigned                 shift;
    int unsigned                 ws;
    int unsigned                 ws_base;
    int unsigned                 roll;
    int unsigned                 off;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.op = OP_READ;
    req_bus.virt_addr = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = spm_pkg::CFG_PAGE_SIZE;
    cfg_bus.data = '0;
    idle_pct = 0;
    stall_pct = 0;
    requests_sent = 0;
    results_seen = 0;
    errors = 0;
    quiet_cycles = 0;
    hits_seen = 0;
    fills_seen = 0;
    writebacks_seen = 0;
    cur_psel = spm_pkg::PSEL_RESET;
    cur_slots = spm_pkg::SLOTS_RESET;
    foreach (tag_mem[i]) tag_mem[i] = '0;
    mru_page = '0;
    mru_slot = '0;
    victim_ptr = 1;
    prev_va = '0;

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CONFIG) begin
        drain_requests();
        write_register(DIRECTED[r].reg_idx, DIRECTED[r].reg_val);
      end else begin
        issue_access(DIRECTED[r].op, DIRECTED[r].addr, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_requests();
      write_register(spm_pkg::CFG_PAGE_SIZE, spm_pkg::CFG_DATA_W'(PHASE_PSEL[p]));
      write_register(spm_pkg::CFG_SLOTS, PHASE_SLOTS[p]);
      idle_pct = PHASE_IDLE[p / 2];
      stall_pct = PHASE_STALL[p / 2];
      shift = page_shift(cur_psel);
      // working set a little larger than the usable slots: tag hits plus evictions
      ws = slot_limit(cur_slots) + 2;
      ws_base = $urandom_range((32'd1 << (spm_pkg::VADDR_W - shift)) - ws - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(99);
        off = $urandom & ((32'd1 << shift) - 1);
        wr = 1'($urandom_range(1));
        if (roll < 40) begin
          va = ((prev_va >> shift) << shift) | spm_pkg::VADDR_W'(off);
        end else if (roll < 85) begin
          va = spm_pkg::VADDR_W'(((ws_base + $urandom_range(ws - 1)) << shift) | off);
        end else begin
          va = spm_pkg::VADDR_W'($urandom);
        end
        issue_access(wr, va, 1'b0, NO_RESULT);
        prev_va = va;
      end
    end

    drain_requests();
    repeat (8) @(posedge clk);
    $display("Checked %0d responses to %0d requests: directed table, then %0d register settings",
             results_seen, requests_sent, RAND_PHASES);
    $display("under four pacing mixes; %0d resident hits, %0d fills, %0d dirty writebacks",
             hits_seen, fills_seen, writebacks_seen);
    if (errors == 0 && pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
